// ===== rtl/core/pyrgb_pkg.sv =====
// shared types, constants and channel clamp for the packed yuv block to rgb unit
`timescale 1ns / 1ps

package pyrgb_pkg;

	localparam int DIM_W   = 10;   // width of the image size registers
	localparam int POS_W   = 9;    // width of the reported block position
	localparam int BYTE_W  = 8;
	localparam int CHAN_W  = 8;
	localparam int PIX_W   = 3 * CHAN_W;
	localparam int LUMA_W  = 9;    // signed luma minus black level
	localparam int PROD_W  = 24;   // signed products and sums
	localparam int FRAC_W  = 12;   // q12 coefficients
	localparam int LANES   = 4;

	localparam logic signed [PROD_W-1:0] Q_Y  = 24'sd4768;
	localparam logic signed [PROD_W-1:0] Q_RV = 24'sd6537;
	localparam logic signed [PROD_W-1:0] Q_GU = 24'sd1602;
	localparam logic signed [PROD_W-1:0] Q_GV = 24'sd3330;
	localparam logic signed [PROD_W-1:0] Q_BU = 24'sd8266;
	localparam logic signed [LUMA_W-1:0] Y_BLACK = 9'sd16;
	localparam logic [CHAN_W-1:0]        CHAN_MAX = 8'hFF;

	localparam logic [DIM_W-1:0] DIM_RESET = 10'd64;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b1;

	typedef struct packed {
		logic s1;
		logic s2;
	} stage_en_t;

	typedef struct packed {
		logic signed [PROD_W-1:0] rv;
		logic signed [PROD_W-1:0] gu;
		logic signed [PROD_W-1:0] gv;
		logic signed [PROD_W-1:0] bu;
	} chroma_t;

	typedef struct packed {
		logic             last;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
	} pos_t;

	// truncate toward zero then clamp: any negative sum ends at zero
	function automatic logic [CHAN_W-1:0] to_channel(input logic signed [PROD_W-1:0] sum);
		logic [PROD_W-FRAC_W-1:0] whole;
		whole = sum[PROD_W-1:FRAC_W];
		if (sum[PROD_W-1]) begin
			to_channel = '0;
		end else if (whole > (PROD_W-FRAC_W)'(CHAN_MAX)) begin
			to_channel = CHAN_MAX;
		end else begin
			to_channel = whole[CHAN_W-1:0];
		end
	endfunction

endpackage

// ===== rtl/core/pyrgb_chroma.sv =====
// shared chroma decode and chroma coefficient products
`timescale 1ns / 1ps

module pyrgb_chroma
	import pyrgb_pkg::*;
(
	input  logic              clk,
	input  stage_en_t         en,
	input  logic [BYTE_W-1:0] byte_tl,
	input  logic [BYTE_W-1:0] byte_tr,
	input  logic [BYTE_W-1:0] byte_bl,
	input  logic [BYTE_W-1:0] byte_br,
	output chroma_t           chroma_s1
);

	logic signed [BYTE_W-1:0] u_val;
	logic signed [BYTE_W-1:0] v_val;
	logic signed [PROD_W-1:0] u_ext;
	logic signed [PROD_W-1:0] v_ext;

	assign u_val = {byte_tl[2:0], byte_tr[2:0], 2'b00};
	assign v_val = {byte_bl[2:0], byte_br[2:0], 2'b00};
	assign u_ext = {{(PROD_W-BYTE_W){u_val[BYTE_W-1]}}, u_val};
	assign v_ext = {{(PROD_W-BYTE_W){v_val[BYTE_W-1]}}, v_val};

	always_ff @(posedge clk) begin
		if (en.s1) begin
			chroma_s1.rv <= Q_RV * v_ext;
			chroma_s1.gu <= Q_GU * u_ext;
			chroma_s1.gv <= Q_GV * v_ext;
			chroma_s1.bu <= Q_BU * u_ext;
		end
	end

endmodule

// ===== rtl/core/pyrgb_lane.sv =====
// one pixel lane: luma product, channel sums and clamp
`timescale 1ns / 1ps

module pyrgb_lane
	import pyrgb_pkg::*;
(
	input  logic              clk,
	input  stage_en_t         en,
	input  logic [BYTE_W-1:0] coded,
	input  chroma_t           chroma_s1,
	output logic [PIX_W-1:0]  pixel_s2
);

	logic signed [LUMA_W-1:0] luma;
	logic signed [PROD_W-1:0] luma_ext;
	logic signed [PROD_W-1:0] luma_s1;
	logic signed [PROD_W-1:0] sum_r;
	logic signed [PROD_W-1:0] sum_g;
	logic signed [PROD_W-1:0] sum_b;

	assign luma     = $signed({1'b0, coded[7:3], 3'b000}) - Y_BLACK;
	assign luma_ext = {{(PROD_W-LUMA_W){luma[LUMA_W-1]}}, luma};

	always_ff @(posedge clk) begin
		if (en.s1) begin
			luma_s1 <= Q_Y * luma_ext;
		end
	end

	assign sum_r = luma_s1 + chroma_s1.rv;
	assign sum_g = luma_s1 - chroma_s1.gu - chroma_s1.gv;
	assign sum_b = luma_s1 + chroma_s1.bu;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			pixel_s2 <= {to_channel(sum_r), to_channel(sum_g), to_channel(sum_b)};
		end
	end

endmodule

// ===== rtl/core/pyrgb_raster.sv =====
// image size registers and raster position counters
`timescale 1ns / 1ps

module pyrgb_raster
	import pyrgb_pkg::*;
#(
	parameter int MAX_BLOCKS_PER_SIDE = 512
)
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data,
	input  logic                 step,
	output pos_t                 pos
);

	localparam int DIM_TOP = (1 << DIM_W) - 1;
	localparam int MAX_EFF = (MAX_BLOCKS_PER_SIDE > DIM_TOP) ? DIM_TOP : MAX_BLOCKS_PER_SIDE;
	localparam logic [DIM_W-1:0] DIM_LIMIT = DIM_W'(MAX_EFF);
	localparam logic [DIM_W-1:0] DIM_ONE   = DIM_W'(1);

	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic [DIM_W-1:0] col_q;
	logic [DIM_W-1:0] row_q;
	logic [DIM_W-1:0] eff_w;
	logic [DIM_W-1:0] eff_h;
	logic [DIM_W:0]   col_next;
	logic [DIM_W:0]   row_next;
	logic             row_end;
	logic             image_end;

	always_comb begin
		eff_w = width_q;
		if (width_q == '0) eff_w = DIM_ONE;
		else if (width_q > DIM_LIMIT) eff_w = DIM_LIMIT;
		eff_h = height_q;
		if (height_q == '0) eff_h = DIM_ONE;
		else if (height_q > DIM_LIMIT) eff_h = DIM_LIMIT;
	end

	assign col_next  = {1'b0, col_q} + (DIM_W+1)'(1);
	assign row_next  = {1'b0, row_q} + (DIM_W+1)'(1);
	assign row_end   = col_next >= {1'b0, eff_w};
	assign image_end = row_end && (row_next >= {1'b0, eff_h});

	assign pos.col  = col_q[POS_W-1:0];
	assign pos.row  = row_q[POS_W-1:0];
	assign pos.last = image_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_RESET;
			height_q <= DIM_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_WIDTH:  width_q  <= cfg_data;
				CFG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (step) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= image_end ? '0 : row_next[DIM_W-1:0];
			end else begin
				col_q <= col_next[DIM_W-1:0];
			end
		end
	end

endmodule

// ===== rtl/core/packed_yuv_block_to_rgb_unit.sv =====
// top level: packed 2x2 yuv block to four rgb888 pixels with raster position
`timescale 1ns / 1ps
// usage
// - input stream (s_*): one request per coded 2x2 block, four bytes in s_tdata
// - output stream (m_*): one request per block, four rgb888 pixels plus the
//   block column and row in m_tdata, m_tlast marks the final block of the image
// - config port: cfg_we writes cfg_data into register cfg_index at a clock edge,
//   index 0 is the width in blocks, index 1 the height; write only when idle
// - pipeline: an accepted block is registered in the multiply stage, then in the
//   sum-and-clamp stage, whose registers drive the output stream
// - throughput: one block per clock while the receiver does not stall, set by
//   the two-stage multiply then sum-and-clamp pipeline of the four pixel lanes and the shared chroma unit
// - chroma products are formed once per block and shared by all four lanes
// - raster position is taken at acceptance and travels with the block
// - reset clears the valid flags and the raster counters, and loads both
//   image dimensions with 64 blocks
// - when the receiver stalls the result holds on m_tdata; a block already in
//   the first stage waits behind it and s_tready drops once both stages hold
//   a block, so nothing is lost and bubbles close up
module packed_yuv_block_to_rgb_unit
	import pyrgb_pkg::*;
#(
	parameter int MAX_BLOCKS_PER_SIDE = 512
)
(
	input  logic                 clk,
	input  logic                 arst_n,
	// config write port
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data,
	// coded block stream
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// byte_top_left, byte_top_right, byte_bottom_left, byte_bottom_right
	input  logic [31:0]          s_tdata,
	// pixel stream
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// pixel_top_left, pixel_top_right, pixel_bottom_left, pixel_bottom_right,
	// block_col, block_row, zero pad to 120 bits
	output logic [119:0]         m_tdata,
	output logic                 m_tlast
);

	logic                   valid_s1;
	logic                   valid_s2;
	logic                   ready_s1;
	logic                   ready_s2;
	logic                   accept;
	stage_en_t              en;
	chroma_t                chroma_s1;
	pos_t                   pos_now;
	pos_t                   pos_s1;
	pos_t                   pos_s2;
	logic [BYTE_W-1:0]      coded [LANES];
	logic [PIX_W-1:0]       pixel_s2 [LANES];

	// a stage moves on when the one after it is empty or moving
	assign ready_s2 = !valid_s2 || m_tready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign s_tready = ready_s1;
	assign accept   = s_tvalid && ready_s1;
	assign en.s1    = ready_s1;
	assign en.s2    = ready_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= s_tvalid;
			if (ready_s2) valid_s2 <= valid_s1;
		end
	end

	pyrgb_raster #(
		.MAX_BLOCKS_PER_SIDE(MAX_BLOCKS_PER_SIDE)
	) u_raster (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.step     (accept),
		.pos      (pos_now)
	);

	// position rides alongside the pixel data
	always_ff @(posedge clk) begin
		if (en.s1) pos_s1 <= pos_now;
		if (en.s2) pos_s2 <= pos_s1;
	end

	pyrgb_chroma u_chroma (
		.clk      (clk),
		.en       (en),
		.byte_tl  (s_tdata[7:0]),
		.byte_tr  (s_tdata[15:8]),
		.byte_bl  (s_tdata[23:16]),
		.byte_br  (s_tdata[31:24]),
		.chroma_s1(chroma_s1)
	);

	// four pixel lanes in parallel
	for (genvar i = 0; i < LANES; i++) begin : g_lane
		assign coded[i] = s_tdata[i*BYTE_W +: BYTE_W];
		pyrgb_lane u_lane (
			.clk      (clk),
			.en       (en),
			.coded    (coded[i]),
			.chroma_s1(chroma_s1),
			.pixel_s2 (pixel_s2[i])
		);
	end

	// merge lanes and position into the output word
	assign m_tvalid = valid_s2;
	assign m_tlast  = pos_s2.last;
	assign m_tdata  = {6'b000000, pos_s2.row, pos_s2.col,
		pixel_s2[3], pixel_s2[2], pixel_s2[1], pixel_s2[0]};

endmodule

// ===== rtl/core/pyrgb_checker.sv =====
// port level checks for the packed yuv block to rgb unit, bound to the top level
`timescale 1ns / 1ps

module pyrgb_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [119:0] m_tdata,
	input logic         m_tlast
);

	// an empty output stage never holds back the input
	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with output stage empty");

	// a moving output keeps the pipeline open
	a_flow_ready: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input stalled while receiver is ready");

	// every accepted block is followed by m_tvalid at the output
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |-> ##2 m_tvalid)
		else $error("accepted block did not reach the output");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
		else $error("stalled result changed");

endmodule

bind packed_yuv_block_to_rgb_unit pyrgb_checker u_pyrgb_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tlast (m_tlast)
);
